/* rtl/core/plc_pkg.sv */
package plc_pkg;

  localparam int DEPTH = 16;
  localparam int POS_W = 5;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DEL_AT  = 2'd1,
    CMD_DEL_VAL = 2'd2,
    CMD_READ_AT = 2'd3
  } plc_cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } plc_status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DEL_AT,
    OP_DEL_VAL
  } plc_op_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] item_value;
    logic [POS_W-1:0]   position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         list_length;
    logic signed [31:0] result_value;
  } out_word_t;

  // per-cell control from the command decode
  typedef struct packed {
    plc_op_t op;
    logic    at;     // cell index equals target index
    logic    after;  // cell index above target index
    logic    live;   // cell holds a list entry
  } plc_cell_ctrl_t;

endpackage

/* rtl/core/positional_list_insert_delete.sv */
// Positional list: an ordered list of up to DEPTH signed 32-bit entries.
// Input channel (in_valid / in_stall / in_word) carries one command word:
// insert at a 1-based position, delete at a position, delete the first
// entry equal to item_value, or read the entry at a position.
// Result channel (out_valid / out_stall / out_word) returns exactly one
// word per command: status, list length after the command, and the
// removed or read entry (zero for insert and on any error).
// The list lives in a row of identical cells; each cell holds one entry,
// and on every command keeps it, takes item_value, or takes its left or
// right neighbor's value. A found-bit ripples through the row to locate
// the first match for delete-by-value.
// out_valid rises in the cycle after acceptance. Throughput: one command
// per cycle while not stalled, set by the single cell update per command.
// The output register parts the two sides; in_stall is raised only while
// a result is held and the receiver stalls it.
// Reset clears the length and the output valid; entry storage is not
// cleared, and entries past the length are never read.
module positional_list_insert_delete
  import plc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  out_word_t        out_word_r;
  out_word_t        out_word_nxt;

  logic             in_fire;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] tgt;        // zero-based target index
  logic [IDX_W-1:0] tgt_idx;
  plc_status_t      status;
  plc_op_t          op;
  logic signed [31:0] rd_val;

  logic signed [31:0] cell_val [DEPTH];
  logic               found    [DEPTH+1];

  assign in_fire = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;

  assign pos_ext = CMP_W'(in_word.position);
  assign cnt_ext = CMP_W'(cnt_r);
  assign tgt     = pos_ext - CMP_W'(1);
  assign tgt_idx = tgt[IDX_W-1:0];
  assign rd_val  = cell_val[tgt_idx];

  assign found[0] = 1'b0;

  // status decode; full is checked before position range
  always_comb begin
    status = ST_OK;
    unique case (plc_cmd_t'(in_word.cmd))
      CMD_INSERT: begin
        if (cnt_ext == CMP_W'(DEPTH)) begin
          status = ST_FULL;
        end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
          status = ST_RANGE;
        end
      end
      CMD_DEL_AT, CMD_READ_AT: begin
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          status = ST_RANGE;
        end
      end
      CMD_DEL_VAL: begin
        if (!found[DEPTH]) begin
          status = ST_NOTFOUND;
        end
      end
      default: status = ST_OK;
    endcase
  end

  always_comb begin
    op           = OP_HOLD;
    cnt_nxt      = cnt_r;
    out_word_nxt = out_word_r;
    if (in_fire) begin
      out_word_nxt.status       = status;
      out_word_nxt.result_value = '0;
      if (status == ST_OK) begin
        unique case (plc_cmd_t'(in_word.cmd))
          CMD_INSERT: begin
            op      = OP_INSERT;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          CMD_DEL_AT: begin
            op      = OP_DEL_AT;
            cnt_nxt = cnt_r - CNT_W'(1);
            out_word_nxt.result_value = rd_val;
          end
          CMD_DEL_VAL: begin
            op      = OP_DEL_VAL;
            cnt_nxt = cnt_r - CNT_W'(1);
            out_word_nxt.result_value = in_word.item_value;
          end
          CMD_READ_AT: begin
            out_word_nxt.result_value = rd_val;
          end
          default: op = OP_HOLD;
        endcase
      end
      out_word_nxt.list_length = 5'(cnt_nxt);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // cell row
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    plc_cell_ctrl_t ctrl;
    logic signed [31:0] left_v;
    logic signed [31:0] right_v;

    assign ctrl.op    = op;
    assign ctrl.at    = (tgt == CMP_W'(k));
    assign ctrl.after = (CMP_W'(k) > tgt);
    assign ctrl.live  = (CMP_W'(k) < cnt_ext);

    if (k == 0) begin : g_first
      assign left_v = cell_val[k];
    end else begin : g_mid_l
      assign left_v = cell_val[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_v = cell_val[k];
    end else begin : g_mid_r
      assign right_v = cell_val[k+1];
    end

    plc_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .item_value (in_word.item_value),
      .left_val   (left_v),
      .right_val  (right_v),
      .found_in   (found[k]),
      .found_out  (found[k+1]),
      .val        (cell_val[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* rtl/core/plc_cell.sv */
module plc_cell
  import plc_pkg::*;
(
  input  logic               clk,
  input  plc_cell_ctrl_t     ctrl,
  input  logic signed [31:0] item_value,
  input  logic signed [31:0] left_val,
  input  logic signed [31:0] right_val,
  input  logic               found_in,
  output logic               found_out,
  output logic signed [31:0] val
);

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;
  logic               match;

  assign match     = ctrl.live && (val_r == item_value);
  assign found_out = found_in | match;
  assign val       = val_r;

  always_comb begin
    val_nxt = val_r;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (ctrl.at) begin
          val_nxt = item_value;
        end else if (ctrl.after) begin
          val_nxt = left_val;
        end
      end
      OP_DEL_AT: begin
        if (ctrl.at || ctrl.after) begin
          val_nxt = right_val;
        end
      end
      OP_DEL_VAL: begin
        // shift from the first matching cell upward
        if (found_out) begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* sim/tb_positional_list_insert_delete.sv */
`timescale 1ns / 100ps

module tb_positional_list_insert_delete;
  import plc_pkg::*;

  // the run is cut here if results stop coming
  localparam int CYCLE_LIMIT = 200000;
  // long receiver hold-off: the output register fills and in_stall rises
  localparam int HOLD_CYCLES = 300;
  // two copies of the list: one checks results, one steers stimulus ahead of time
  localparam int PRED   = 0;
  localparam int SHADOW = 1;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  positional_list_insert_delete u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // list contents and length, per copy
  logic signed [31:0] list_mem [2][DEPTH];
  int                 list_len [2];

  in_word_t  pending_words [$];   // command words not yet offered
  out_word_t expected_words [$];  // results owed by the block, oldest first

  int   fail_count  = 0;
  int   cycle_count = 0;
  logic word_taken  = 1'b0;       // in_word was accepted at the last rising edge
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_req    = 1'b0;       // asks the receiver for one long hold-off
  logic filling     = 1'b1;       // random mix drifts toward full, then toward empty

  // ---------------------------------------------------------------------------
  // List behavior
  // ---------------------------------------------------------------------------

  // close the gap left by the entry at idx
  function automatic void drop_entry(input int c, input int idx);
    int k;
    for (k = idx; k + 1 < list_len[c]; k++) list_mem[c][k] = list_mem[c][k + 1];
    list_len[c]--;
  endfunction

  // applies one command word to copy c and returns the result word it owes
  function automatic out_word_t list_step(input int c, input in_word_t w);
    out_word_t r;
    int        p;
    int        k;
    int        hit;
    p = int'(w.position);
    r.status       = ST_OK;
    r.result_value = '0;
    case (w.cmd)
      CMD_INSERT: begin
        // full is checked before the position
        if (list_len[c] >= DEPTH) r.status = ST_FULL;
        else if (p == 0 || p > list_len[c] + 1) r.status = ST_RANGE;
        else begin
          for (k = list_len[c]; k > p - 1; k--) list_mem[c][k] = list_mem[c][k - 1];
          list_mem[c][p - 1] = w.item_value;
          list_len[c]++;
        end
      end
      CMD_DEL_AT, CMD_READ_AT: begin
        if (p == 0 || p > list_len[c]) r.status = ST_RANGE;
        else begin
          r.result_value = list_mem[c][p - 1];
          if (w.cmd == CMD_DEL_AT) drop_entry(c, p - 1);
        end
      end
      default: begin
        // first match from the head; a head match is removed like any other
        hit = -1;
        for (k = 0; k < list_len[c]; k++)
          if (hit < 0 && list_mem[c][k] == w.item_value) hit = k;
        if (hit < 0) r.status = ST_NOTFOUND;
        else begin
          r.result_value = list_mem[c][hit];
          drop_entry(c, hit);
        end
      end
    endcase
    r.list_length = 5'(list_len[c]);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_word(input plc_cmd_t cmd, input logic [31:0] value, input int pos);
    in_word_t w;
    w.cmd        = cmd;
    w.item_value = value;
    w.position   = POS_W'(pos);
    void'(list_step(SHADOW, w));
    pending_words.push_back(w);
  endtask

  // small pool gives duplicates and delete-value hits; extremes show up often
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 32'($urandom_range(0, 6)) - 32'd3;
    if (r < 35) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // mostly meaningful commands; about one in seven carries a random position
  task automatic queue_random(input int count);
    int          n;
    int          len;
    int          r;
    int          ins_pct;
    int          pos;
    plc_cmd_t    cmd;
    logic [31:0] value;
    for (n = 0; n < count; n++) begin
      len = list_len[SHADOW];
      if (len >= DEPTH) filling = 1'b0;
      else if (len == 0) filling = 1'b1;
      ins_pct = filling ? 55 : 15;
      r = $urandom_range(0, 99);
      if (r < ins_pct) cmd = CMD_INSERT;
      else if (r < ins_pct + (100 - ins_pct) / 3) cmd = CMD_DEL_AT;
      else if (r < ins_pct + 2 * (100 - ins_pct) / 3) cmd = CMD_DEL_VAL;
      else cmd = CMD_READ_AT;

      if ($urandom_range(0, 99) < 15) pos = $urandom_range(0, 31);
      else if (cmd == CMD_INSERT) pos = $urandom_range(1, len + 1);
      else if (len > 0) pos = $urandom_range(1, len);
      else pos = $urandom_range(0, 31);

      if (cmd == CMD_INSERT) value = pick_value();
      else if (cmd == CMD_DEL_VAL) begin
        if (len > 0 && $urandom_range(0, 99) < 70)
          value = list_mem[SHADOW][$urandom_range(0, len - 1)];
        else value = pick_value();
      end else value = $urandom;

      queue_word(cmd, value, pos);
    end
  endtask

  task automatic wait_sent();
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and the test sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : sequence_blk
    int i;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    list_len[PRED]   = 0;
    list_len[SHADOW] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words: empty list, fill to full with extremes and duplicates,
    // then full, range and match cases
    send_idle_pct = 21;
    recv_idle_pct = 71;
    queue_word(CMD_INSERT, 32'd5, 0);          // position zero
    queue_word(CMD_READ_AT, 32'd0, 1);         // read on empty list
    queue_word(CMD_DEL_VAL, 32'd0, 1);         // no match on empty list
    for (i = 0; i < DEPTH; i++) begin
      case (i % 3)
        0: queue_word(CMD_INSERT,
                      (i == 0) ? 32'h7fff_ffff : (i == 3) ? 32'h8000_0000 : 32'd7, 1);
        1: queue_word(CMD_INSERT, $urandom, i + 1);     // append
        default: queue_word(CMD_INSERT, 32'd7, i / 2 + 1);
      endcase
    end
    queue_word(CMD_INSERT, 32'd1, 0);          // full wins over bad position
    queue_word(CMD_INSERT, 32'd1, DEPTH + 1);
    queue_word(CMD_READ_AT, 32'd0, DEPTH);
    queue_word(CMD_READ_AT, 32'd0, DEPTH + 1); // one past the end
    queue_word(CMD_DEL_VAL, 32'd7, 0);         // first of several duplicates
    queue_word(CMD_DEL_VAL, list_mem[SHADOW][0], 31); // head match
    queue_word(CMD_DEL_AT, 32'd0, 0);
    queue_word(CMD_DEL_AT, 32'd0, list_len[SHADOW]);  // tail
    queue_word(CMD_DEL_VAL, 32'h0bad_cafe, 3);

    queue_random(700);
    wait_sent();

    send_idle_pct = 71;
    recv_idle_pct = 21;
    queue_random(700);
    wait_sent();

    // no idling; the receiver's hold-off backs the block up against the sender
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(600);
    hold_req = 1'b1;
    wait_sent();

    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers the next pending word at the falling edge; a word stays
  // put until it has been taken
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : drive_blk
    logic     next_valid;
    in_word_t next_word;
    next_valid = in_valid;
    next_word  = in_word;
    if (rst_n && (!in_valid || word_taken)) begin
      next_valid = 1'b0;
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_word  = pending_words.pop_front();
        next_valid = 1'b1;
      end
    end
    in_valid <= next_valid;
    in_word  <= next_word;
  end

  // receiver: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin : stall_blk
    static int   hold_left = 0;
    static logic hold_done = 1'b0;
    if (rst_n) begin
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge, check a taken result against the oldest
  // expectation, then predict the result of a taken command word
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor_blk
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, out_word);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("status", 32'(want.status), 32'(out_word.status));
          check_field("list_length", 32'(want.list_length), 32'(out_word.list_length));
          check_field("result_value", want.result_value, out_word.result_value);
        end
      end
      if (in_valid && !in_stall) expected_words.push_back(list_step(PRED, in_word));
    end
    word_taken <= rst_n && in_valid && !in_stall;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
